### hdl/sbb_pkg.sv
// Shared types, constants and the microcode table of the bit-bang word sequencer.
// Used by sbb_sequencer, sbb_datapath and serial_bit_bang_word_sequencer_core.
`default_nettype none

package sbb_pkg;

  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned PORTION_BITS = 16;
  localparam int unsigned CNT_BITS     = $clog2(WORD_BITS + 1);
  localparam int unsigned POS_BITS     = 5;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DAT_BITS = 5;
  localparam int unsigned DAC_PORTIONS = 2;

  typedef struct packed {
    logic                 kind;
    logic [5:0]           count;
    logic [WORD_BITS-1:0] data_word;
    logic [WORD_BITS-1:0] base_word;
  } in_word_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] pin_word;
    logic                 clock_pulse;
    logic                 error;
    logic                 last;
  } out_word_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRONT_DATA_BIT  = 3'd0,
    CFG_FRONT_CLOCK_BIT = 3'd1,
    CFG_DAC_DATA_BIT    = 3'd2,
    CFG_DAC_CLOCK_BIT   = 3'd3,
    CFG_SYNC_BIT        = 3'd4,
    CFG_SYNC_ACTIVE_HI  = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    STEP_ERR      = 4'd0,
    STEP_F_HEAD   = 4'd1,
    STEP_F_BIT    = 4'd2,
    STEP_F_TAIL   = 4'd3,
    STEP_D_HEAD   = 4'd4,
    STEP_D_STROBE = 4'd5,
    STEP_D_BIT    = 4'd6,
    STEP_D_HOLD   = 4'd7,
    STEP_D_REL    = 4'd8,
    STEP_D_TAIL   = 4'd9
  } step_e;

  typedef enum logic [2:0] {
    PIN_ZERO     = 3'd0,
    PIN_BASE     = 3'd1,
    PIN_REL      = 3'd2,
    PIN_ACT      = 3'd3,
    PIN_BIT_BASE = 3'd4,
    PIN_BIT_ACT  = 3'd5
  } pin_sel_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_BITS     = 2'd1,
    COND_PORTIONS = 2'd2
  } cond_e;

  typedef struct packed {
    pin_sel_e pin_sel;
    logic     clock_pulse;
    logic     error;
    logic     last;
    logic     shift;
    logic     clr_bits;
    logic     inc_portion;
    cond_e    cond;
    step_e    target;
    logic     done;
  } ctrl_word_t;

  typedef struct packed {
    logic       load;
    logic       step;
    ctrl_word_t cw;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_valid;
    logic more_bits;
    logic more_portions;
  } dp_status_t;

  function automatic ctrl_word_t sbb_rom(step_e pc);
    ctrl_word_t cw;
    cw = '{pin_sel: PIN_ZERO, clock_pulse: 1'b0, error: 1'b0, last: 1'b0,
           shift: 1'b0, clr_bits: 1'b0, inc_portion: 1'b0, cond: COND_NEXT,
           target: STEP_ERR, done: 1'b0};
    unique case (pc)
      STEP_ERR: begin
        cw.error = 1'b1;
        cw.last  = 1'b1;
        cw.done  = 1'b1;
      end
      STEP_F_HEAD: begin
        cw.pin_sel = PIN_BASE;
      end
      STEP_F_BIT: begin
        cw.pin_sel     = PIN_BIT_BASE;
        cw.clock_pulse = 1'b1;
        cw.shift       = 1'b1;
        cw.cond        = COND_BITS;
        cw.target      = STEP_F_BIT;
      end
      STEP_F_TAIL: begin
        cw.pin_sel = PIN_BASE;
        cw.last    = 1'b1;
        cw.done    = 1'b1;
      end
      STEP_D_HEAD: begin
        cw.pin_sel = PIN_REL;
      end
      STEP_D_STROBE: begin
        cw.pin_sel  = PIN_ACT;
        cw.clr_bits = 1'b1;
      end
      STEP_D_BIT: begin
        cw.pin_sel     = PIN_BIT_ACT;
        cw.clock_pulse = 1'b1;
        cw.shift       = 1'b1;
        cw.cond        = COND_BITS;
        cw.target      = STEP_D_BIT;
      end
      STEP_D_HOLD: begin
        cw.pin_sel = PIN_ACT;
      end
      STEP_D_REL: begin
        cw.pin_sel     = PIN_REL;
        cw.inc_portion = 1'b1;
        cw.cond        = COND_PORTIONS;
        cw.target      = STEP_D_STROBE;
      end
      STEP_D_TAIL: begin
        cw.pin_sel = PIN_REL;
        cw.last    = 1'b1;
        cw.done    = 1'b1;
      end
      default: begin
        cw.error = 1'b1;
        cw.last  = 1'b1;
        cw.done  = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

### hdl/sbb_sequencer.sv
// Step counter, microcode fetch and jump logic of the bit-bang word sequencer.
// Depends on sbb_pkg for the microcode table and control types.
`default_nettype none

module sbb_sequencer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  sbb_pkg::in_word_t    in_word_i,
  output logic                 in_stall_o,
  input  wire                  out_stall_i,
  input  sbb_pkg::dp_status_t  status_i,
  output sbb_pkg::dp_ctrl_t    ctrl_o
);

  logic               active_q, active_d;
  sbb_pkg::step_e     pc_q, pc_d;
  sbb_pkg::ctrl_word_t cw;
  sbb_pkg::step_e     entry;
  logic               accept, step, count_ok;

  assign cw         = sbb_pkg::sbb_rom(pc_q);
  assign in_stall_o = active_q;
  assign accept     = in_valid_i && !active_q;
  assign step       = active_q && (!status_i.out_valid || !out_stall_i);

  always_comb begin
    if (in_word_i.kind) begin
      count_ok = (in_word_i.count == 6'd1) ||
                 (in_word_i.count == 6'(sbb_pkg::DAC_PORTIONS));
    end else begin
      count_ok = (in_word_i.count != 6'd0) &&
                 (in_word_i.count <= 6'(sbb_pkg::WORD_BITS));
    end
    priority if (!count_ok) begin
      entry = sbb_pkg::STEP_ERR;
    end else if (in_word_i.kind) begin
      entry = sbb_pkg::STEP_D_HEAD;
    end else begin
      entry = sbb_pkg::STEP_F_HEAD;
    end
  end

  always_comb begin
    active_d = active_q;
    pc_d     = pc_q;
    if (accept) begin
      active_d = 1'b1;
      pc_d     = entry;
    end else if (step) begin
      if (cw.done) begin
        active_d = 1'b0;
      end else begin
        unique case (cw.cond)
          sbb_pkg::COND_BITS:
            pc_d = status_i.more_bits ? cw.target : sbb_pkg::step_e'(pc_q + 4'd1);
          sbb_pkg::COND_PORTIONS:
            pc_d = status_i.more_portions ? cw.target : sbb_pkg::step_e'(pc_q + 4'd1);
          default:
            pc_d = sbb_pkg::step_e'(pc_q + 4'd1);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pc_q     <= sbb_pkg::STEP_ERR;
    end else begin
      active_q <= active_d;
      pc_q     <= pc_d;
    end
  end

  assign ctrl_o.load = accept;
  assign ctrl_o.step = step;
  assign ctrl_o.cw   = cw;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> active_q)
    else $error("accepted command did not start the sequencer");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && cw.last) |=> !active_q)
    else $error("sequencer still active after final word");

  a_entry_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> (pc_q == sbb_pkg::STEP_ERR || pc_q == sbb_pkg::STEP_F_HEAD ||
                         pc_q == sbb_pkg::STEP_D_HEAD))
    else $error("program entered at a step that is no entry point");

  a_step_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_i.out_valid && out_stall_i) |-> !step)
    else $error("step taken while output word is stalled");

endmodule

`default_nettype wire

### hdl/sbb_datapath.sv
// Shift register, counters, pin-word builder, output register and pin-position registers.
// Driven by the control word from sbb_sequencer; depends on sbb_pkg.
`default_nettype none

module sbb_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_valid_i,
  input  wire [sbb_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire [sbb_pkg::CFG_DAT_BITS-1:0]       cfg_data_i,
  input  sbb_pkg::in_word_t                     in_word_i,
  input  sbb_pkg::dp_ctrl_t                     ctrl_i,
  input  wire                                   out_stall_i,
  output logic                                  out_valid_o,
  output sbb_pkg::out_word_t                    out_word_o,
  output sbb_pkg::dp_status_t                   status_o
);

  localparam int unsigned W = sbb_pkg::WORD_BITS;
  localparam int unsigned C = sbb_pkg::CNT_BITS;
  localparam int unsigned P = sbb_pkg::POS_BITS;

  logic [P-1:0]   front_data_q, dac_data_q, sync_pos_q;
  logic           sync_high_q;

  logic           kind_q;
  logic [5:0]     count_q;
  logic [W-1:0]   base_q, shift_q;
  logic [C-1:0]   bit_cnt_q, bit_limit_q;
  logic [1:0]     portion_q;

  logic           out_valid_q;
  sbb_pkg::out_word_t out_q;

  logic [W-1:0]   dmask, smask, act, rel, bit_src, pin;
  logic [C-1:0]   bit_next;
  logic [5:0]     portion_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_data_q <= P'(0);
      dac_data_q   <= P'(2);
      sync_pos_q   <= P'(4);
      sync_high_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (sbb_pkg::cfg_idx_e'(cfg_index_i))
        sbb_pkg::CFG_FRONT_DATA_BIT: front_data_q <= cfg_data_i[P-1:0];
        sbb_pkg::CFG_DAC_DATA_BIT:   dac_data_q   <= cfg_data_i[P-1:0];
        sbb_pkg::CFG_SYNC_BIT:       sync_pos_q   <= cfg_data_i[P-1:0];
        sbb_pkg::CFG_SYNC_ACTIVE_HI: sync_high_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign dmask    = W'(1) << (kind_q ? dac_data_q : front_data_q);
  assign smask    = W'(1) << sync_pos_q;
  assign act      = sync_high_q ? (base_q | smask) : (base_q & ~smask);
  assign rel      = sync_high_q ? (base_q & ~smask) : (base_q | smask);
  assign bit_next = bit_cnt_q + C'(1);
  assign portion_next = {4'd0, portion_q} + 6'd1;

  always_comb begin
    bit_src = (ctrl_i.cw.pin_sel == sbb_pkg::PIN_BIT_ACT) ? act : base_q;
    unique case (ctrl_i.cw.pin_sel)
      sbb_pkg::PIN_BASE:     pin = base_q;
      sbb_pkg::PIN_REL:      pin = rel;
      sbb_pkg::PIN_ACT:      pin = act;
      sbb_pkg::PIN_BIT_BASE,
      sbb_pkg::PIN_BIT_ACT:  pin = shift_q[0] ? (bit_src | dmask) : (bit_src & ~dmask);
      default:               pin = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      kind_q      <= in_word_i.kind;
      count_q     <= in_word_i.count;
      base_q      <= in_word_i.base_word;
      shift_q     <= in_word_i.data_word;
      bit_cnt_q   <= '0;
      bit_limit_q <= in_word_i.kind ? C'(sbb_pkg::PORTION_BITS) : in_word_i.count[C-1:0];
      portion_q   <= '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.cw.shift) begin
        shift_q   <= shift_q >> 1;
        bit_cnt_q <= bit_next;
      end else if (ctrl_i.cw.clr_bits) begin
        bit_cnt_q <= '0;
      end
      if (ctrl_i.cw.inc_portion) begin
        portion_q <= portion_q + 2'd1;
      end
    end
    if (ctrl_i.step) begin
      out_q.pin_word    <= pin;
      out_q.clock_pulse <= ctrl_i.cw.clock_pulse;
      out_q.error       <= ctrl_i.cw.error;
      out_q.last        <= ctrl_i.cw.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_word_o             = out_q;
  assign status_o.out_valid     = out_valid_q;
  assign status_o.more_bits     = bit_next < bit_limit_q;
  assign status_o.more_portions = portion_next < count_q;

endmodule

`default_nettype wire

### hdl/serial_bit_bang_word_sequencer_core.sv
// Top level of the bit-bang word sequencer: one shift command in, a run of port words out.
// Instantiates sbb_sequencer and sbb_datapath; depends on sbb_pkg.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one command word (kind, count,
//   data_word, base_word). Output channel: out_valid_o / out_stall_i carry port words
//   (pin_word, clock_pulse, error, last); last marks the final word of a command.
//   Config channel: cfg_valid_i / cfg_ready_o, always ready; write only while idle.
//   A front-end command gives count+2 words, a DAC command 2+19*count words, a bad
//   count a single error word. The microcode program emits one word per cycle while
//   the output is not stalled. On acceptance the step counter is loaded, and the first
//   word then passes into the output register. The next command is taken the cycle
//   after the final step, while that final word may still sit in the output register.
//   A stalled output holds its word and freezes the step counter.
//   Reset clears the sequencer and the output valid and restores the pin positions
//   (front data 0, DAC data 2, sync 4, sync active high). Clock pin positions are
//   accepted on the config port and have no effect on the port words.
`default_nettype none

module serial_bit_bang_word_sequencer_core (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  input  sbb_pkg::in_word_t                  in_word_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  output sbb_pkg::out_word_t                 out_word_o,
  input  wire                                out_stall_i,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [sbb_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire [sbb_pkg::CFG_DAT_BITS-1:0]    cfg_data_i
);

  sbb_pkg::dp_ctrl_t   ctrl;
  sbb_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sbb_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  sbb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .ctrl_i      (ctrl),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .status_o    (status)
  );

endmodule

`default_nettype wire

### dv/serial_bit_bang_word_sequencer_core_tb.sv
// Testbench for serial_bit_bang_word_sequencer_core: shift commands in, checked port words out.
// Predicts every port word from its own copy of the pin registers; depends on sbb_pkg.
`timescale 1ns / 100ps

module serial_bit_bang_word_sequencer_core_tb;

  localparam logic KIND_FRONT = 1'b0;
  localparam logic KIND_DAC   = 1'b1;
  localparam logic [sbb_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [sbb_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  sbb_pkg::in_word_t                in_word_i   = '0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  sbb_pkg::out_word_t               out_word_o;
  logic                             out_stall_i = 1'b0;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [sbb_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [sbb_pkg::CFG_DAT_BITS-1:0] cfg_data_i  = '0;

  logic [4:0] front_data_pos = 5'd0;
  logic [4:0] dac_data_pos   = 5'd2;
  logic [4:0] sync_pos       = 5'd4;
  logic       sync_high      = 1'b1;

  sbb_pkg::out_word_t port_words_q[$];
  bit gaps_on = 1'b1;
  int stall_left = 0;
  int mismatches = 0;
  int n_cmds = 0;
  int n_bad_cmds = 0;
  int n_words = 0;
  int n_reg_writes = 0;

  serial_bit_bang_word_sequencer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic void push_word(logic [31:0] pin, logic clk, logic err, logic fin);
    sbb_pkg::out_word_t w;
    w.pin_word    = pin;
    w.clock_pulse = clk;
    w.error       = err;
    w.last        = fin;
    port_words_q.push_back(w);
  endfunction

  function automatic void expand_command(sbb_pkg::in_word_t cmd);
    logic [31:0] sr, dmask, smask, act, rel, lvl;
    bit ok;
    ok = (cmd.kind == KIND_FRONT) ? (cmd.count >= 6'd1 && cmd.count <= 6'd32)
                                  : (cmd.count == 6'd1 || cmd.count == 6'd2);
    if (!ok) begin
      push_word('0, 1'b0, 1'b1, 1'b1);
      n_bad_cmds++;
      return;
    end
    sr = cmd.data_word;
    if (cmd.kind == KIND_FRONT) begin
      dmask = 32'd1 << front_data_pos;
      push_word(cmd.base_word, 1'b0, 1'b0, 1'b0);
      for (int i = 0; i < cmd.count; i++) begin
        lvl = sr[0] ? (cmd.base_word | dmask) : (cmd.base_word & ~dmask);
        push_word(lvl, 1'b1, 1'b0, 1'b0);
        sr = sr >> 1;
      end
      push_word(cmd.base_word, 1'b0, 1'b0, 1'b1);
    end else begin
      dmask = 32'd1 << dac_data_pos;
      smask = 32'd1 << sync_pos;
      act = sync_high ? (cmd.base_word | smask) : (cmd.base_word & ~smask);
      rel = sync_high ? (cmd.base_word & ~smask) : (cmd.base_word | smask);
      push_word(rel, 1'b0, 1'b0, 1'b0);
      for (int j = 0; j < cmd.count; j++) begin
        push_word(act, 1'b0, 1'b0, 1'b0);
        for (int i = 0; i < sbb_pkg::PORTION_BITS; i++) begin
          lvl = sr[0] ? (act | dmask) : (act & ~dmask);
          push_word(lvl, 1'b1, 1'b0, 1'b0);
          sr = sr >> 1;
        end
        push_word(act, 1'b0, 1'b0, 1'b0);
        push_word(rel, 1'b0, 1'b0, 1'b0);
      end
      push_word(rel, 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function automatic sbb_pkg::in_word_t mk_cmd(logic k, logic [5:0] c, logic [31:0] d,
                                               logic [31:0] b);
    sbb_pkg::in_word_t w;
    w.kind      = k;
    w.count     = c;
    w.data_word = d;
    w.base_word = b;
    return w;
  endfunction

  function automatic sbb_pkg::in_word_t rand_cmd();
    logic       k;
    logic [5:0] c;
    k = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0)
      c = 6'($urandom_range(0, 63));
    else if (k == KIND_FRONT)
      c = 6'($urandom_range(1, 32));
    else
      c = 6'($urandom_range(1, 2));
    return mk_cmd(k, c, $urandom, $urandom);
  endfunction

  task automatic send_cmd(sbb_pkg::in_word_t cmd);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    expand_command(cmd);
    n_cmds++;
  endtask

  // drop the command valid and drain every pending word
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (port_words_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sbb_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [sbb_pkg::CFG_DAT_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_reg_writes++;
    case (idx)
      sbb_pkg::CFG_FRONT_DATA_BIT: front_data_pos = val;
      sbb_pkg::CFG_DAC_DATA_BIT:   dac_data_pos   = val;
      sbb_pkg::CFG_SYNC_BIT:       sync_pos       = val;
      sbb_pkg::CFG_SYNC_ACTIVE_HI: sync_high      = val[0];
      default: ;
    endcase
  endtask

  task automatic set_pins(logic [4:0] fd, logic [4:0] fc, logic [4:0] dd, logic [4:0] dc,
                          logic [4:0] sy, logic [4:0] hi);
    wait_idle();
    write_reg(sbb_pkg::CFG_FRONT_DATA_BIT, fd);
    write_reg(sbb_pkg::CFG_FRONT_CLOCK_BIT, fc);
    write_reg(sbb_pkg::CFG_DAC_DATA_BIT, dd);
    write_reg(sbb_pkg::CFG_DAC_CLOCK_BIT, dc);
    write_reg(sbb_pkg::CFG_SYNC_BIT, sy);
    write_reg(sbb_pkg::CFG_SYNC_ACTIVE_HI, hi);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_front_end();
    send_cmd(mk_cmd(KIND_FRONT, 6'd1, 32'hFFFF_FFFF, 32'h0000_0000));
    send_cmd(mk_cmd(KIND_FRONT, 6'd32, 32'hFFFF_FFFF, 32'h0000_0000));
    send_cmd(mk_cmd(KIND_FRONT, 6'd32, 32'h0000_0000, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(KIND_FRONT, 6'd17, $urandom, $urandom));
    wait_idle();
  endtask

  task automatic test_dac();
    send_cmd(mk_cmd(KIND_DAC, 6'd1, 32'h0000_FFFF, 32'h0000_0000));
    send_cmd(mk_cmd(KIND_DAC, 6'd2, 32'hA5A5_5A5A, 32'hFFFF_FFFF));
    set_pins(5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd0);
    send_cmd(mk_cmd(KIND_DAC, 6'd2, 32'hFFFF_0000, 32'h0000_0000));
    wait_idle();
  endtask

  task automatic test_bad_count();
    send_cmd(mk_cmd(KIND_FRONT, 6'd0, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_FRONT, 6'd33, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_FRONT, 6'd63, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_DAC, 6'd0, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_DAC, 6'd3, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_DAC, 6'd63, $urandom, $urandom));
    wait_idle();
  endtask

  task automatic test_pin_collision();
    set_pins(5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd1);
    send_cmd(mk_cmd(KIND_FRONT, 6'd32, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_DAC, 6'd2, 32'h0F0F_F0F0, $urandom));
    set_pins(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(mk_cmd(KIND_DAC, 6'd2, 32'h3C3C_C3C3, $urandom));
    wait_idle();
  endtask

  task automatic test_spare_regs();
    set_pins(5'd31, 5'd0, 5'd16, 5'd31, 5'd1, 5'd1);
    write_reg(CFG_SPARE_6, 5'd31);
    write_reg(CFG_SPARE_7, 5'd31);
    cfg_valid_i <= 1'b0;
    send_cmd(mk_cmd(KIND_FRONT, 6'd8, $urandom, $urandom));
    send_cmd(mk_cmd(KIND_DAC, 6'd1, $urandom, $urandom));
    wait_idle();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_pins(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
               5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
               5'($urandom_range(0, 31)), 5'($urandom_range(0, 1)));
      for (int i = 0; i < per_phase; i++) send_cmd(rand_cmd());
    end
    wait_idle();
  endtask

  task automatic test_no_gaps(int n);
    gaps_on = 1'b0;
    set_pins(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
             5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
             5'($urandom_range(0, 31)), 5'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) send_cmd(rand_cmd());
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    sbb_pkg::out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (port_words_q.size() == 0) begin
          $error("unexpected port word %h", out_word_o);
          mismatches++;
        end else begin
          want = port_words_q.pop_front();
          n_words++;
          if (out_word_o.pin_word !== want.pin_word) begin
            $error("pin_word: expected %h, got %h", want.pin_word, out_word_o.pin_word);
            mismatches++;
          end
          if (out_word_o.clock_pulse !== want.clock_pulse) begin
            $error("clock_pulse: expected %b, got %b", want.clock_pulse,
                   out_word_o.clock_pulse);
            mismatches++;
          end
          if (out_word_o.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, out_word_o.error);
            mismatches++;
          end
          if (out_word_o.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_word_o.last);
            mismatches++;
          end
        end
      end
      if (stall_left != 0)
        stall_left--;
      else if (gaps_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 17);
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin
    #15_000_000;
    $display("serial_bit_bang_word_sequencer_core regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_front_end();
    test_dac();
    test_bad_count();
    test_pin_collision();
    test_spare_regs();
    test_random(5, 60);
    test_no_gaps(50);
    repeat (8) @(posedge clk_i);
    $display("covered %0d commands (%0d with a bad count), %0d port words checked",
             n_cmds, n_bad_cmds, n_words);
    $display("pin registers written %0d times, %0d mismatches", n_reg_writes, mismatches);
    if (mismatches == 0 && port_words_q.size() == 0)
      $display("serial_bit_bang_word_sequencer_core regression: pass");
    else
      $display("serial_bit_bang_word_sequencer_core regression: fail");
    $finish;
  end

endmodule

### serial_bit_bang_word_sequencer_core.f
hdl/sbb_pkg.sv
hdl/sbb_sequencer.sv
hdl/sbb_datapath.sv
hdl/serial_bit_bang_word_sequencer_core.sv
dv/serial_bit_bang_word_sequencer_core_tb.sv
